### src/lrht_pkg.sv
// Shared types and constants for the layer rectangle hit test block.
// Used by every module of the block; depends on nothing else.
package lrht_pkg;

    // Table size and coordinate width.
    localparam int MAX_LAYERS = 64;
    localparam int COORD_BITS = 20;
    localparam int ADDR_BITS  = $clog2(MAX_LAYERS);

    // Field widths of the request and the count register.
    localparam int IDX_BITS   = 6;
    localparam int CNT_BITS   = 7;

    // Action codes carried by a request.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic                         action;
        logic [IDX_BITS-1:0]          entry_index;
        logic signed [COORD_BITS-1:0] left_edge;
        logic signed [COORD_BITS-1:0] top_edge;
        logic [COORD_BITS-1:0]        span_x;
        logic [COORD_BITS-1:0]        span_y;
        logic                         shown;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_req;

    // One result of a query.
    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] layer_index;
    } t_rsp;

    // One stored layer rectangle.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0]        width;
        logic [COORD_BITS-1:0]        height;
        logic                         visible;
    } t_entry;

    // Write port request into the layer table.
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        t_entry               data;
    } t_wr_req;

    // Read port request into the layer table.
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
    } t_rd_req;

endpackage

### src/lrht_ram.sv
// Layer table: one synchronous memory with one write and one read port.
// Read data is registered and appears in the cycle after the read request. Depends on lrht_pkg.
module lrht_ram
    import lrht_pkg::*;
(
    input  logic    i_clk,
    input  t_wr_req i_wr,
    input  t_rd_req i_rd,
    output t_entry  o_rd_data
);

    t_entry r_mem [MAX_LAYERS];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/lrht_scan.sv
// Query sequencer: walks the layer table one entry per cycle, tests each
// rectangle against the query point and reports the first hit or a miss. Depends on lrht_pkg.
module lrht_scan
    import lrht_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic [CNT_BITS-1:0]          i_limit,
    input  t_entry                       i_rd_data,
    output t_rd_req                      o_rd,
    output logic                         o_busy,
    output logic                         o_done,
    output t_rsp                         o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                         r_state;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic [CNT_BITS-1:0]          r_limit;
    logic [CNT_BITS-1:0]          r_addr;
    logic                         r_rd_valid;
    logic [ADDR_BITS-1:0]         r_rd_idx;
    logic                         r_done;
    t_rsp                         r_rsp;

    logic                         issue;
    logic                         hit;
    logic                         last;
    logic signed [COORD_BITS+1:0] px_w;
    logic signed [COORD_BITS+1:0] py_w;
    logic signed [COORD_BITS+1:0] l_w;
    logic signed [COORD_BITS+1:0] t_w;
    logic signed [COORD_BITS+1:0] r_edge;
    logic signed [COORD_BITS+1:0] b_edge;

    // Issue one read per cycle until every searched entry has been requested or a hit ends the scan.
    assign issue      = (r_state == ST_SCAN) && (r_addr < r_limit);
    assign o_rd.en    = issue;
    assign o_rd.addr  = r_addr[ADDR_BITS-1:0];

    // Containment test on the entry just read. Edges are two bits wider, so a
    // full-width span added to the largest offset cannot wrap.
    always_comb begin
        px_w   = {{2{r_px[COORD_BITS-1]}}, r_px};
        py_w   = {{2{r_py[COORD_BITS-1]}}, r_py};
        l_w    = {{2{i_rd_data.left[COORD_BITS-1]}}, i_rd_data.left};
        t_w    = {{2{i_rd_data.top[COORD_BITS-1]}}, i_rd_data.top};
        r_edge = l_w + $signed({2'b00, i_rd_data.width});
        b_edge = t_w + $signed({2'b00, i_rd_data.height});
        hit    = r_rd_valid && i_rd_data.visible
                 && (px_w >= l_w) && (py_w >= t_w)
                 && (px_w < r_edge) && (py_w < b_edge);
        last   = r_rd_valid
                 && ((CNT_BITS'(r_rd_idx) + CNT_BITS'(1)) == r_limit);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_rd_valid <= 1'b0;
                    if (i_go) begin
                        if (i_limit == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_rd_valid <= issue;
                    if (hit || last) begin
                        r_done     <= 1'b1;
                        r_state    <= ST_IDLE;
                        r_rd_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Query point, counters and result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_go) begin
            r_px    <= i_px;
            r_py    <= i_py;
            r_limit <= i_limit;
            r_addr  <= '0;
            r_rsp   <= '0;
        end else if (r_state == ST_SCAN) begin
            if (issue) begin
                r_addr   <= r_addr + CNT_BITS'(1);
                r_rd_idx <= r_addr[ADDR_BITS-1:0];
            end
            if (hit) begin
                r_rsp.found       <= 1'b1;
                r_rsp.layer_index <= IDX_BITS'(r_rd_idx);
            end else begin
                r_rsp <= '0;
            end
        end
    end

    assign o_busy = (r_state == ST_SCAN);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

### src/layer_rectangle_hit_test.sv
// Top level of the layer rectangle hit test: count register, request decode,
// layer table and query sequencer. Depends on lrht_pkg, lrht_ram, lrht_scan.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   A write request (action write) stores one layer rectangle in the table
//   in that same edge; it gives no result and never raises busy.
//   A query request searches the first layer_count entries (capped at the
//   table size) in order from entry zero and reports the first visible
//   rectangle holding the point on o_rsp, marked by o_done for one cycle.
//   The table is read one entry per cycle from its single read port. busy is
//   high while the scan runs and drops as o_done rises, so a new request is
//   taken only once the current query has finished; a query over zero
//   entries never raises busy.
//   The result is offered once and cannot be held off by the receiver.
//   Reset clears the count register and the sequencer; table contents are
//   undefined until written. layer_count is written through i_cfg_we and
//   i_cfg_wdata; the user must write it only while no query is in flight,
//   which the block itself does not enforce.
module layer_rectangle_hit_test
    import lrht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_req                i_req,
    output logic                o_done,
    output t_rsp                o_rsp,
    input  logic                i_cfg_we,
    input  logic [CNT_BITS-1:0] i_cfg_wdata
);

    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_LAYERS);

    logic [CNT_BITS-1:0] r_layer_count;
    logic                accept;
    logic [CNT_BITS-1:0] limit;
    t_wr_req             wr;
    t_rd_req             rd;
    t_entry              rd_data;
    logic                scan_busy;

    // Count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= '0;
        end else if (i_cfg_we) begin
            r_layer_count <= i_cfg_wdata;
        end
    end

    // Request decode: writes go straight to the table.
    assign accept = start && !scan_busy;
    assign limit  = (r_layer_count > MAX_CNT) ? MAX_CNT : r_layer_count;

    always_comb begin
        wr.en           = accept && (i_req.action == ACT_WRITE)
                          && ({1'b0, i_req.entry_index} < (IDX_BITS + 1)'(MAX_LAYERS));
        wr.addr         = ADDR_BITS'(i_req.entry_index);
        wr.data.left    = i_req.left_edge;
        wr.data.top     = i_req.top_edge;
        wr.data.width   = i_req.span_x;
        wr.data.height  = i_req.span_y;
        wr.data.visible = i_req.shown;
    end

    lrht_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    lrht_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (accept && (i_req.action == ACT_QUERY)),
        .i_px      (i_req.point_x),
        .i_py      (i_req.point_y),
        .i_limit   (limit),
        .i_rd_data (rd_data),
        .o_rd      (rd),
        .o_busy    (scan_busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp)
    );

    assign busy = scan_busy;

endmodule

### tb/lrht_checker.sv
// Checker for the layer rectangle hit test: mirrors the layer table and the count
// register, predicts the answer to each query request and compares it with o_rsp.
// Depends on lrht_pkg only; it watches the ports of the block and drives nothing into it.
module lrht_checker
    import lrht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  t_req                i_req,
    input  logic                o_done,
    input  t_rsp                o_rsp,
    input  logic                i_cfg_we,
    input  logic [CNT_BITS-1:0] i_cfg_wdata,
    output int                  fail_count,
    output int                  pending
);

    t_entry              layer_tab [MAX_LAYERS];
    logic [CNT_BITS-1:0] layer_count_q;
    t_rsp                hit_q [$];
    t_rsp                want;

    initial begin
        fail_count    = 0;
        pending       = 0;
        layer_count_q = '0;
    end

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        if (fail_count < 200) begin
            $display("lrht_checker: %s: got %0d, expected %0d at %0t",
                     what, got, exp_val, $realtime);
        end
        fail_count++;
    endtask

    // Answer to a query: the lowest visible entry among the searched ones whose
    // half-open rectangle holds the point. Sums are done in 32 bits, so no overflow.
    function automatic t_rsp topmost_hit(input logic signed [COORD_BITS-1:0] px,
                                         input logic signed [COORD_BITS-1:0] py);
        t_rsp ans;
        int   n;
        int   x;
        int   y;
        int   lx;
        int   ty;
        ans = '0;
        x   = int'(px);
        y   = int'(py);
        n   = (int'(layer_count_q) > MAX_LAYERS) ? MAX_LAYERS : int'(layer_count_q);
        for (int i = 0; i < n; i++) begin
            lx = int'(layer_tab[i].left);
            ty = int'(layer_tab[i].top);
            if (!ans.found && layer_tab[i].visible &&
                x >= lx && y >= ty &&
                x < lx + int'(layer_tab[i].width) &&
                y < ty + int'(layer_tab[i].height)) begin
                ans.found       = 1'b1;
                ans.layer_index = i[IDX_BITS-1:0];
            end
        end
        return ans;
    endfunction

    // All values are sampled as they stood before the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            layer_count_q = '0;
            hit_q.delete();
        end else begin
            // A finished query is matched against the oldest prediction.
            if (o_done) begin
                if (hit_q.size() == 0) begin
                    flag_mismatch("result with no query waiting", int'(o_rsp.found), 0);
                end else begin
                    want = hit_q.pop_front();
                    if (o_rsp.found !== want.found) begin
                        flag_mismatch("found", int'(o_rsp.found), int'(want.found));
                    end
                    if (o_rsp.layer_index !== want.layer_index) begin
                        flag_mismatch("layer_index", int'(o_rsp.layer_index),
                                      int'(want.layer_index));
                    end
                end
            end

            // An accepted request either loads an entry or queues a prediction.
            if (start && !busy) begin
                if (i_req.action == ACT_WRITE) begin
                    if (int'(i_req.entry_index) < MAX_LAYERS) begin
                        layer_tab[i_req.entry_index].left    = i_req.left_edge;
                        layer_tab[i_req.entry_index].top     = i_req.top_edge;
                        layer_tab[i_req.entry_index].width   = i_req.span_x;
                        layer_tab[i_req.entry_index].height  = i_req.span_y;
                        layer_tab[i_req.entry_index].visible = i_req.shown;
                    end
                end else begin
                    hit_q.push_back(topmost_hit(i_req.point_x, i_req.point_y));
                end
            end

            // The count register takes effect for requests after this edge.
            if (i_cfg_we) begin
                layer_count_q = i_cfg_wdata;
            end
        end
        pending <= hit_q.size();
    end

endmodule

### tb/tb_layer_rectangle_hit_test.sv
// Testbench top for the layer rectangle hit test: clock, reset, request stimulus
// and the verdict. Depends on lrht_pkg, layer_rectangle_hit_test and lrht_checker.
module tb_layer_rectangle_hit_test;
    import lrht_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    t_req                req       = '0;
    logic                done;
    t_rsp                rsp;
    logic                cfg_we    = 1'b0;
    logic [CNT_BITS-1:0] cfg_wdata = '0;
    int                  mismatches;
    int                  queries_open;

    // Stimulus-side copy of the rectangles, used only to aim query points.
    int sh_left [MAX_LAYERS];
    int sh_top  [MAX_LAYERS];
    int sh_w    [MAX_LAYERS];
    int sh_h    [MAX_LAYERS];
    bit written [MAX_LAYERS];
    int eff_layers  = 0;
    int sender_idle = 0;
    int plan [12]   = '{64, 5, 127, 0, 1, -1, 65, 64, 2, -1, 63, 100};

    layer_rectangle_hit_test u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_done      (done),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    lrht_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_done      (done),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .fail_count  (mismatches),
        .pending     (queries_open)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(12 * 600000);
        $display("tb: failure");
        $finish;
    end

    // Presents one request after a random gap and returns at its accepting edge.
    task automatic issue(input t_req r);
        int idx;
        while ($urandom_range(0, 99) < sender_idle) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (r.action == ACT_WRITE) begin
            idx          = int'(r.entry_index);
            sh_left[idx] = int'(r.left_edge);
            sh_top[idx]  = int'(r.top_edge);
            sh_w[idx]    = int'(r.span_x);
            sh_h[idx]    = int'(r.span_y);
            written[idx] = 1'b1;
        end
    endtask

    // Holds off until every query has answered and the block has gone quiet.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (queries_open != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_count(input int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[CNT_BITS-1:0];
        @(posedge clk);
        cfg_we     <= 1'b0;
        eff_layers = (value > MAX_LAYERS) ? MAX_LAYERS : value;
    endtask

    // Fields that an action ignores carry random values.
    function automatic t_req noise_req();
        t_req r;
        r        = {$urandom(), $urandom(), $urandom(), $urandom()};
        r.span_x = COORD_BITS'($urandom_range(0, 524288));
        r.span_y = COORD_BITS'($urandom_range(0, 524288));
        return r;
    endfunction

    task automatic write_layer(input int slot, input int l, input int t,
                               input int w, input int h, input bit vis);
        t_req r;
        r             = noise_req();
        r.action      = ACT_WRITE;
        r.entry_index = IDX_BITS'(slot);
        r.left_edge   = COORD_BITS'(l);
        r.top_edge    = COORD_BITS'(t);
        r.span_x      = COORD_BITS'(w);
        r.span_y      = COORD_BITS'(h);
        r.shown       = vis;
        issue(r);
    endtask

    task automatic query_point(input int x, input int y);
        t_req r;
        r         = noise_req();
        r.action  = ACT_QUERY;
        r.point_x = COORD_BITS'(x);
        r.point_y = COORD_BITS'(y);
        issue(r);
    endtask

    // Mostly small overlapping rectangles, some anywhere, some at the extremes.
    task automatic random_layer(input int slot);
        int l;
        int t;
        int w;
        int h;
        case ($urandom_range(0, 9))
            0: begin
                l = int'($urandom_range(0, 1048575)) - 524288;
                t = int'($urandom_range(0, 1048575)) - 524288;
                w = $urandom_range(0, 524288);
                h = $urandom_range(0, 524288);
            end
            1: begin
                l = $urandom_range(0, 1) ? -524288 : 524287;
                t = $urandom_range(0, 1) ? -524288 : 524287;
                w = $urandom_range(0, 1) ? 524288 : 0;
                h = 524288;
            end
            default: begin
                l = int'($urandom_range(0, 400)) - 200;
                t = int'($urandom_range(0, 400)) - 200;
                w = $urandom_range(0, 120);
                h = $urandom_range(0, 120);
            end
        endcase
        write_layer(slot, l, t, w, h, $urandom_range(0, 3) != 0);
    endtask

    // Points inside a searched entry, on or just outside its border, near the origin, or anywhere at all.
    task automatic random_query();
        int m;
        int j;
        int x;
        int y;
        m = $urandom_range(0, 9);
        if (eff_layers > 0 && m < 8) begin
            j = $urandom_range(0, eff_layers - 1);
            if (m < 5) begin
                x = sh_left[j] + ((sh_w[j] > 0) ? int'($urandom_range(0, sh_w[j] - 1)) : 0);
                y = sh_top[j] + ((sh_h[j] > 0) ? int'($urandom_range(0, sh_h[j] - 1)) : 0);
            end else begin
                case ($urandom_range(0, 3))
                    0:       x = sh_left[j] - 1;
                    1:       x = sh_left[j];
                    2:       x = sh_left[j] + sh_w[j] - 1;
                    default: x = sh_left[j] + sh_w[j];
                endcase
                case ($urandom_range(0, 3))
                    0:       y = sh_top[j] - 1;
                    1:       y = sh_top[j];
                    2:       y = sh_top[j] + sh_h[j] - 1;
                    default: y = sh_top[j] + sh_h[j];
                endcase
            end
        end else if (m == 8) begin
            x = int'($urandom_range(0, 500)) - 250;
            y = int'($urandom_range(0, 500)) - 250;
        end else begin
            x = int'($urandom_range(0, 1048575)) - 524288;
            y = int'($urandom_range(0, 1048575)) - 524288;
        end
        query_point(x, y);
    endtask

    initial begin
        int cnt;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty search, extreme rectangles, empty and hidden layers.
        sender_idle = 27;
        set_count(0);
        query_point(-524288, -524288);
        write_layer(0, -524288, -524288, 524288, 524288, 1'b1);
        write_layer(1, 0, 0, 0, 10, 1'b1);
        write_layer(2, 100, 100, 10, 10, 1'b0);
        write_layer(3, 100, 100, 10, 10, 1'b1);
        write_layer(4, 524287, 524287, 524288, 524288, 1'b1);
        write_layer(5, 0, 0, 10, 0, 1'b1);
        set_count(6);
        query_point(-524288, -524288);
        query_point(-1, -1);
        query_point(0, -1);
        query_point(0, 0);
        query_point(100, 100);
        query_point(109, 109);
        query_point(110, 105);
        query_point(105, 99);
        query_point(524287, 524287);
        query_point(5, 5);
        set_count(3);
        query_point(100, 100);

        // Random phases: each sets a count, fills any unwritten searched entry,
        // then mixes writes and queries.
        for (int ph = 0; ph < 12; ph++) begin
            sender_idle = (ph < 4) ? 27 : (ph < 8) ? 62 : 0;
            cnt = (plan[ph] < 0) ? int'($urandom_range(1, 126)) : plan[ph];
            set_count(cnt);
            for (int s = 0; s < eff_layers; s++) begin
                if (!written[s]) random_layer(s);
            end
            repeat (100) begin
                if ($urandom_range(0, 99) < 30) begin
                    random_layer($urandom_range(0, MAX_LAYERS - 1));
                end else begin
                    random_query();
                end
            end
        end

        // Drain and give the block time to show any stray result.
        settle();
        repeat (70) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### layer_rectangle_hit_test.f
src/lrht_pkg.sv
src/lrht_ram.sv
src/lrht_scan.sv
src/layer_rectangle_hit_test.sv
tb/lrht_checker.sv
tb/tb_layer_rectangle_hit_test.sv
